@@ rtl/cfc_pkg.sv @@
// Shared constants, codes and types of the centered FIR correlator.
// Used by every module under rtl; depends on nothing else.
package cfc_pkg;

	localparam int MAX_TAPS      = 16;
	localparam int SAMPLE_BITS   = 16;
	localparam int COEF_BITS     = 16;
	localparam int PROD_BITS     = SAMPLE_BITS + COEF_BITS;
	localparam int GROUP         = 4;
	localparam int GROUPS        = MAX_TAPS / GROUP;
	localparam int PART_BITS     = PROD_BITS + 2;
	localparam int OUT_BITS      = 36;
	localparam int TAP_WORDS     = 4;
	localparam int CNT_BITS      = 5;
	localparam int HALF_BITS     = 4;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 64;
	localparam int QUEUE_DEPTH   = 4;
	localparam int QPTR_BITS     = 2;
	localparam int QCNT_BITS     = 3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_BITS-1:0] REG_TAP_COUNT = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_TAPS_0    = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_TAPS_1    = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_TAPS_2    = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_TAPS_3    = 3'd4;

	// One step for the back end: shift a sample in, maybe give an output,
	// maybe clear the delay line afterwards.
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          emit;
		logic                          last;
		logic                          clear;
	} cmd_t;

	typedef struct packed {
		logic flushing;
		logic pushing;
	} front_stat_t;

	typedef logic [TAP_WORDS-1:0][CFG_DATA_BITS-1:0] tap_words_t;

endpackage

@@ rtl/cfc_front.sv @@
// Front end: accepts samples, tracks the sequence count and expands the final
// sample into zero-padded flush steps. Depends on cfc_pkg.
module cfc_front import cfc_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          final_sample,
	input  logic [CNT_BITS-1:0]           taps_act,
	output logic                          cmd_push,
	output cmd_t                          cmd,
	input  logic                          cmd_full,
	output front_stat_t                   stat
);

	logic [CNT_BITS-1:0]  seen_q;
	logic [CNT_BITS-1:0]  seen_hold_q;
	logic [HALF_BITS-1:0] half_q;
	logic [HALF_BITS-1:0] z_q;
	logic                 flush_q;

	logic [HALF_BITS-1:0] half;
	logic [CNT_BITS-1:0]  seen_n;
	logic                 accept;
	logic                 flush_step;
	logic                 flush_end;

	assign half       = taps_act[HALF_BITS:1];
	assign full       = flush_q || cmd_full;
	assign accept     = push && !full;
	assign flush_step = flush_q && !cmd_full;
	assign flush_end  = (z_q == half_q);
	assign seen_n     = (seen_q == CNT_BITS'(MAX_TAPS)) ? seen_q : seen_q + 1'b1;

	assign cmd_push      = accept || flush_step;
	assign stat.flushing = flush_q;
	assign stat.pushing  = cmd_push;

	always_comb begin
		if (flush_q) begin
			cmd.sample = '0;
			// Output index seen-1+z is due once it reaches half.
			cmd.emit   = ({1'b0, seen_hold_q} + {2'b00, z_q}) > {2'b00, half_q};
			cmd.last   = flush_end;
			cmd.clear  = flush_end;
		end else begin
			cmd.sample = sample;
			cmd.emit   = seen_n > {1'b0, half};
			cmd.last   = final_sample && (half == '0);
			cmd.clear  = final_sample && (half == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= '0;
			flush_q <= 1'b0;
			z_q     <= '0;
		end else if (accept) begin
			if (final_sample) begin
				seen_q <= '0;
				if (half != '0) begin
					flush_q <= 1'b1;
					z_q     <= HALF_BITS'(1);
				end
			end else begin
				seen_q <= seen_n;
			end
		end else if (flush_step) begin
			if (flush_end) begin
				flush_q <= 1'b0;
			end else begin
				z_q <= z_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && final_sample) begin
			seen_hold_q <= seen_n;
			half_q      <= half;
		end
	end

endmodule

@@ rtl/cfc_cmd_queue.sv @@
// Short queue of steps between the front end and the filter back end.
// Depends on cfc_pkg.
module cfc_cmd_queue import cfc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t din,
	output logic full,
	input  logic pop,
	output cmd_t dout,
	output logic empty
);

	cmd_t                 mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_q;
	logic [QPTR_BITS-1:0] rd_q;
	logic [QCNT_BITS-1:0] cnt_q;
	logic                 do_push;
	logic                 do_pop;

	assign full    = (cnt_q == QCNT_BITS'(QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule

@@ rtl/cfc_back.sv @@
// Back end: delay line, one multiplier lane per tap, a registered adder tree
// and the result queue. Depends on cfc_pkg.
module cfc_back import cfc_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [CNT_BITS-1:0]        taps_act,
	input  tap_words_t                 tap_words,
	input  cmd_t                       cmd,
	input  logic                       cmd_empty,
	output logic                       cmd_pop,
	input  logic                       pop,
	output logic                       empty,
	output logic signed [OUT_BITS-1:0] filtered,
	output logic                       final_output
);

	logic signed [SAMPLE_BITS-1:0] win_q   [MAX_TAPS];
	logic signed [SAMPLE_BITS-1:0] shifted [MAX_TAPS];
	logic signed [COEF_BITS-1:0]   coef_q  [MAX_TAPS];
	logic signed [COEF_BITS-1:0]   coef_n  [MAX_TAPS];
	logic signed [PROD_BITS-1:0]   prod_s1 [MAX_TAPS];
	logic signed [PART_BITS-1:0]   part_s2 [GROUPS];
	logic signed [PART_BITS-1:0]   part_n  [GROUPS];
	logic signed [OUT_BITS-1:0]    sum_n;
	logic signed [OUT_BITS-1:0]    sum_s3;
	logic                          v_s1, v_s2, v_s3;
	logic                          last_s1, last_s2, last_s3;
	logic                          advance;
	logic                          out_push;

	logic signed [OUT_BITS-1:0]    res_q  [QUEUE_DEPTH];
	logic                          resl_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0]          owr_q;
	logic [QPTR_BITS-1:0]          ord_q;
	logic [QCNT_BITS-1:0]          ocnt_q;
	logic                          out_full;
	logic                          out_pop;

	// Tap taps-1-i lines up with delay line position i; unused positions get zero.
	always_comb begin
		logic [CNT_BITS-1:0] idx;
		for (int i = 0; i < MAX_TAPS; i++) begin
			idx = taps_act - CNT_BITS'(i) - CNT_BITS'(1);
			if (CNT_BITS'(i) < taps_act) begin
				coef_n[i] = tap_words[idx[3:2]][{idx[1:0], 4'b0000} +: COEF_BITS];
			end else begin
				coef_n[i] = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_TAPS; i++) begin
			coef_q[i] <= coef_n[i];
		end
	end

	// The whole pipeline holds while a finished result cannot enter the queue.
	assign advance  = !(v_s3 && out_full);
	assign cmd_pop  = advance && !cmd_empty;
	assign out_push = advance && v_s3;

	always_comb begin
		shifted[0] = cmd.sample;
		for (int i = 1; i < MAX_TAPS; i++) begin
			shifted[i] = win_q[i-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TAPS; i++) begin
				win_q[i] <= '0;
			end
		end else if (cmd_pop) begin
			for (int i = 0; i < MAX_TAPS; i++) begin
				win_q[i] <= cmd.clear ? '0 : shifted[i];
			end
		end
	end

	always_comb begin
		for (int g = 0; g < GROUPS; g++) begin
			part_n[g] = '0;
			for (int k = 0; k < GROUP; k++) begin
				part_n[g] = part_n[g] + PART_BITS'(prod_s1[g*GROUP + k]);
			end
		end
		sum_n = '0;
		for (int g = 0; g < GROUPS; g++) begin
			sum_n = sum_n + OUT_BITS'(part_s2[g]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (advance) begin
			v_s1 <= cmd_pop && cmd.emit;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < MAX_TAPS; i++) begin
				prod_s1[i] <= coef_q[i] * shifted[i];
			end
			last_s1 <= cmd.last;
			for (int g = 0; g < GROUPS; g++) begin
				part_s2[g] <= part_n[g];
			end
			last_s2 <= last_s1;
			sum_s3  <= sum_n;
			last_s3 <= last_s2;
		end
	end

	// Result queue.
	assign out_full     = (ocnt_q == QCNT_BITS'(QUEUE_DEPTH));
	assign empty        = (ocnt_q == '0);
	assign out_pop      = pop && !empty;
	assign filtered     = res_q[ord_q];
	assign final_output = resl_q[ord_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= '0;
			ord_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (out_push) begin
				owr_q <= owr_q + 1'b1;
			end
			if (out_pop) begin
				ord_q <= ord_q + 1'b1;
			end
			if (out_push && !out_pop) begin
				ocnt_q <= ocnt_q + 1'b1;
			end else if (out_pop && !out_push) begin
				ocnt_q <= ocnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_push) begin
			res_q[owr_q]  <= sum_s3;
			resl_q[owr_q] <= last_s3;
		end
	end

endmodule

@@ rtl/centered_fir_correlator_top.sv @@
// Centered FIR correlator, top level: configuration registers, front end,
// step queue and filter back end. Depends on cfc_pkg and the cfc_* modules.
// Throughput: one sample per cycle while the step queue has room; a final sample
// adds taps/2 flush steps in the front end, during which full stays high.
// A step that makes an output passes through the step queue, the multiplier
// lane registers and two registered adder tree stages into the result queue.
// Reset clears the delay line, counters, queues and taps; tap_count goes to 1.
module centered_fir_correlator_top import cfc_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                       final_sample,
	output logic                       empty,
	input  logic                       pop,
	output logic signed [OUT_BITS-1:0] filtered,
	output logic                       final_output,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [CFG_DATA_BITS-1:0]   cfg_data
);

	logic [CNT_BITS-1:0] tap_count_q;
	tap_words_t          taps_q;
	logic [CNT_BITS-1:0] taps_act;
	logic                cfg_we;

	cmd_t                cmd_in;
	cmd_t                cmd_out;
	logic                cmd_push;
	logic                cmd_full;
	logic                cmd_pop;
	logic                cmd_empty;
	front_stat_t         front_stat;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= CNT_BITS'(1);
			taps_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TAP_COUNT: tap_count_q <= cfg_data[CNT_BITS-1:0];
				REG_TAPS_0:    taps_q[0]   <= cfg_data;
				REG_TAPS_1:    taps_q[1]   <= cfg_data;
				REG_TAPS_2:    taps_q[2]   <= cfg_data;
				REG_TAPS_3:    taps_q[3]   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		priority if (tap_count_q == '0) begin
			taps_act = CNT_BITS'(1);
		end else if (tap_count_q > CNT_BITS'(MAX_TAPS)) begin
			taps_act = CNT_BITS'(MAX_TAPS);
		end else begin
			taps_act = tap_count_q;
		end
	end

	cfc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.sample       (sample),
		.final_sample (final_sample),
		.taps_act     (taps_act),
		.cmd_push     (cmd_push),
		.cmd          (cmd_in),
		.cmd_full     (cmd_full),
		.stat         (front_stat)
	);

	cfc_cmd_queue u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.din    (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.dout   (cmd_out),
		.empty  (cmd_empty)
	);

	cfc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.taps_act     (taps_act),
		.tap_words    (taps_q),
		.cmd          (cmd_out),
		.cmd_empty    (cmd_empty),
		.cmd_pop      (cmd_pop),
		.pop          (pop),
		.empty        (empty),
		.filtered     (filtered),
		.final_output (final_output)
	);

	// The front end never pushes a step into a full queue.
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(front_stat.pushing && cmd_full))
		else $error("step pushed into a full queue");

	// A final item with at least two taps starts a flush that blocks input.
	a_flush_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && final_sample && (taps_act > CNT_BITS'(1)))
		|=> (full && front_stat.flushing))
		else $error("final item did not start a flush");

	// No new item is taken while a flush is under way.
	a_flush_holds_full: assert property (@(posedge clk) disable iff (!arst_n)
		front_stat.flushing |-> full)
		else $error("input open during flush");

endmodule
